FILE: design/gca_pkg.sv
// ----------------------------------------------------------------------------
// gca_pkg - shared types and constants for the greedy capacity assignment unit
// Field widths, table depths, item kinds, result codes and controller states.
// ----------------------------------------------------------------------------
package gca_pkg;

   // table sizes
   localparam int CLUSTERS   = 64;
   localparam int CL_W       = $clog2(CLUSTERS);
   localparam int NCL_W      = 7;
   localparam int OBS_DEPTH  = 4096;
   localparam int OBS_W      = $clog2(OBS_DEPTH);
   localparam int CAP_W      = 9;
   localparam int SLOT_W     = 8;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int EPOCH_W    = 4;

   localparam logic [CAP_W-1:0]   MAX_SLOTS   = 9'd256;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'hF;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 4'd0;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_CAPACITY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAIR     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEW_RUN  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

   // result codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TAKEN    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FINISHED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CL   = 3'd4;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } gca_state_type;

endpackage

FILE: design/gca_ram.sv
// ----------------------------------------------------------------------------
// gca_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data valid next cycle.
// ----------------------------------------------------------------------------
module gca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/greedy_capacity_assignment_unit.sv
// ----------------------------------------------------------------------------
// greedy_capacity_assignment_unit - greedy capacitated pair assignment
// Loads cluster capacities, assigns sorted (cluster, observation) pairs while
// the cluster has room and the observation is free, and starts new runs.
//
//   channel | dir | handshake               | word
//   --------+-----+-------------------------+-----------------------------------
//   req     | in  | req_tvalid / req_tready | tuser kind, tdata cluster/obs/cap
//   rsp     | out | rsp_tvalid / rsp_tready | tuser status/clusters_full, tdata slot
//   csr     | in  | csr_valid  / csr_ready  | num_clusters
//
// Each item is first read from the capacity, count and observation-tag memories
// (registered read), then decided and written back; no new item is taken meanwhile.
// After reset, and after every 15th new run, the observation-tag memory is swept
// (one entry a cycle) while req_tready is low.
// A stalled rsp word holds the unit in its decide cycle; one finished word
// can wait while the next item is accepted and read.
// ----------------------------------------------------------------------------
module greedy_capacity_assignment_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [5:0] cluster_index, [17:6] observation_id, [26:18] capacity_value
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: [1:0] kind
   input  logic [1:0]  req_tuser,
   // rsp_tdata: [5:0] assigned_cluster, [13:6] slot_index, [25:14] assigned_observation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // rsp_tuser: [2:0] status, [3] clusters_full
   output logic [3:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int CLUSTERS = gca_pkg::CLUSTERS;
   localparam int CL_W     = gca_pkg::CL_W;
   localparam int NCL_W    = gca_pkg::NCL_W;
   localparam int OBS_W    = gca_pkg::OBS_W;
   localparam int CAP_W    = gca_pkg::CAP_W;
   localparam int SLOT_W   = gca_pkg::SLOT_W;
   localparam int KIND_W   = gca_pkg::KIND_W;
   localparam int STATUS_W = gca_pkg::STATUS_W;
   localparam int EPOCH_W  = gca_pkg::EPOCH_W;

   // control state
   gca_pkg::gca_state_type state_ff, state_in;
   logic [NCL_W-1:0]    num_clusters_ff;
   logic [CLUSTERS-1:0] cap_valid_ff, cap_valid_in;
   logic [CLUSTERS-1:0] cnt_valid_ff, cnt_valid_in;
   logic [CLUSTERS-1:0] nonfull_ff, nonfull_in;
   logic [CLUSTERS-1:0] capnz_ff, capnz_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [OBS_W-1:0]    sweep_ff, sweep_in;

   // held item
   logic [KIND_W-1:0] kind_ff;
   logic [CL_W-1:0]   cl_ff;
   logic [OBS_W-1:0]  obs_ff;
   logic [CAP_W-1:0]  capv_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CL_W-1:0]     rsp_cluster_ff, rsp_cluster_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [OBS_W-1:0]    rsp_obs_ff, rsp_obs_in;
   logic                rsp_full_ff, rsp_full_in;

   // memory ports
   logic               req_accept;
   logic               cap_wr_en, cnt_wr_en, tag_wr_en;
   logic [CAP_W-1:0]   cap_wr_data, cnt_wr_data;
   logic [CAP_W-1:0]   cap_rd, cnt_rd;
   logic [OBS_W-1:0]   tag_wr_addr;
   logic [EPOCH_W-1:0] tag_wr_data, tag_rd;

   // decide-cycle signals
   logic [CLUSTERS-1:0] active_mask;
   logic [CAP_W-1:0]    cap_cur, cnt_cur, cnt_next, cap_sat;
   logic                taken, full_before, proceed;

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // capacity, count and observation-tag memories
   gca_ram #(.WIDTH(CAP_W), .DEPTH(CLUSTERS)) u_cap_ram (
      .clock   (clock),
      .wr_en   (cap_wr_en),
      .wr_addr (cl_ff),
      .wr_data (cap_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[CL_W-1:0]),
      .rd_data (cap_rd)
   );

   gca_ram #(.WIDTH(CAP_W), .DEPTH(CLUSTERS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cl_ff),
      .wr_data (cnt_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[CL_W-1:0]),
      .rd_data (cnt_rd)
   );

   gca_ram #(.WIDTH(EPOCH_W), .DEPTH(gca_pkg::OBS_DEPTH)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[CL_W +: OBS_W]),
      .rd_data (tag_rd)
   );

   // active clusters: index below num_clusters (values above 64 cover all)
   always_comb begin
      for (int c = 0; c < CLUSTERS; c++) begin
         active_mask[c] = (NCL_W'(c) < num_clusters_ff);
      end
   end

   // capacity entries never written since reset, and count entries never written since the run start, read as zero
   assign cap_cur     = cap_valid_ff[cl_ff] ? cap_rd : '0;
   assign cnt_cur     = cnt_valid_ff[cl_ff] ? cnt_rd : '0;
   assign cnt_next    = cnt_cur + CAP_W'(1);
   assign cap_sat     = (capv_ff > gca_pkg::MAX_SLOTS) ? gca_pkg::MAX_SLOTS : capv_ff;
   assign taken       = (tag_rd == epoch_ff);
   assign full_before = ~|(nonfull_ff & active_mask);
   assign proceed     = (state_ff == gca_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // controller: next state, write-backs and result
   always_comb begin
      state_in       = state_ff;
      cap_valid_in   = cap_valid_ff;
      cnt_valid_in   = cnt_valid_ff;
      nonfull_in     = nonfull_ff;
      capnz_in       = capnz_ff;
      epoch_in       = epoch_ff;
      sweep_in       = sweep_ff;
      cap_wr_en      = 1'b0;
      cnt_wr_en      = 1'b0;
      tag_wr_en      = 1'b0;
      cap_wr_data    = cap_sat;
      cnt_wr_data    = cnt_next;
      tag_wr_addr    = obs_ff;
      tag_wr_data    = epoch_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_obs_in     = rsp_obs_ff;
      rsp_full_in    = rsp_full_ff;
      req_tready     = 1'b0;

      unique case (state_ff)
         gca_pkg::ST_CLEAR: begin
            // sweep every tag entry to the never-current mark
            tag_wr_en   = 1'b1;
            tag_wr_addr = sweep_ff;
            tag_wr_data = gca_pkg::EPOCH_NONE;
            sweep_in    = sweep_ff + OBS_W'(1);
            if (&sweep_ff) begin
               state_in = gca_pkg::ST_IDLE;
            end
         end
         gca_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = gca_pkg::ST_EXEC;
            end
         end
         gca_pkg::ST_EXEC: begin
            if (proceed) begin
               state_in       = gca_pkg::ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = gca_pkg::STATUS_OK;
               rsp_cluster_in = '0;
               rsp_slot_in    = '0;
               rsp_obs_in     = '0;
               case (kind_ff)
                  gca_pkg::KIND_CAPACITY: begin
                     cap_wr_en           = 1'b1;
                     cap_valid_in[cl_ff] = 1'b1;
                     capnz_in[cl_ff]     = (cap_sat != '0);
                     nonfull_in[cl_ff]   = (cnt_cur < cap_sat);
                  end
                  gca_pkg::KIND_NEW_RUN: begin
                     cnt_valid_in = '0;
                     nonfull_in   = capnz_ff;
                     if (epoch_ff == gca_pkg::EPOCH_LAST) begin
                        epoch_in = gca_pkg::EPOCH_FIRST;
                        sweep_in = '0;
                        state_in = gca_pkg::ST_CLEAR;
                     end else begin
                        epoch_in = epoch_ff + EPOCH_W'(1);
                     end
                  end
                  gca_pkg::KIND_PAIR: begin
                     if (full_before) begin
                        rsp_status_in = gca_pkg::STATUS_FINISHED;
                     end else if ({1'b0, cl_ff} >= num_clusters_ff) begin
                        rsp_status_in = gca_pkg::STATUS_BAD_CL;
                     end else if (cnt_cur >= cap_cur) begin
                        rsp_status_in = gca_pkg::STATUS_FULL;
                     end else if (taken) begin
                        rsp_status_in = gca_pkg::STATUS_TAKEN;
                     end else begin
                        // accept: take the slot, bump the count, mark the observation
                        rsp_cluster_in      = cl_ff;
                        rsp_slot_in         = cnt_cur[SLOT_W-1:0];
                        rsp_obs_in          = obs_ff;
                        cnt_wr_en           = 1'b1;
                        tag_wr_en           = 1'b1;
                        cnt_valid_in[cl_ff] = 1'b1;
                        nonfull_in[cl_ff]   = (cnt_next < cap_cur);
                     end
                  end
                  default: begin
                     // unused kind: no write-back, answered with STATUS_OK
                  end
               endcase
               rsp_full_in = ~|(nonfull_in & active_mask);
            end
         end
         default: begin
            state_in = gca_pkg::ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= gca_pkg::ST_CLEAR;
         num_clusters_ff <= NCL_W'(1);
         cap_valid_ff    <= '0;
         cnt_valid_ff    <= '0;
         nonfull_ff      <= '0;
         capnz_ff        <= '0;
         epoch_ff        <= gca_pkg::EPOCH_FIRST;
         sweep_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_valid_ff <= cap_valid_in;
         cnt_valid_ff <= cnt_valid_in;
         nonfull_ff   <= nonfull_in;
         capnz_ff     <= capnz_in;
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            num_clusters_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= req_tuser;
         cl_ff   <= req_tdata[CL_W-1:0];
         obs_ff  <= req_tdata[CL_W +: OBS_W];
         capv_ff <= req_tdata[CL_W+OBS_W +: CAP_W];
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_obs_ff     <= rsp_obs_in;
      rsp_full_ff    <= rsp_full_in;
   end

   // result word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_obs_ff, rsp_slot_ff, rsp_cluster_ff};
   assign rsp_tuser  = {rsp_full_ff, rsp_status_ff};

endmodule
